FILE: sv/towik_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the three-wheel omni inverse kinematics core.
package towik_pkg;

  // Pipeline depth of each wheel lane; the valid chain in the top level matches it.
  localparam int NUM_STAGES = 7;

  localparam int DEFAULT_SINE_TABLE_ENTRIES = 1024;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_LEVER_ARM_GAIN = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_SCALE   = 8'd1;

  // Unity gain in unsigned Q8.8.
  localparam logic [15:0] GAIN_ONE = 16'd256;

  // Binary angle offsets for 30 and 60 degrees, rounded to the nearest step.
  localparam logic [15:0] ANGLE_ZERO    = 16'd0;
  localparam logic [15:0] ANGLE_30      = 16'd5461;
  localparam logic [15:0] ANGLE_60      = 16'd10923;
  localparam logic [15:0] QUARTER_TURN  = 16'd16384;

  // How a wheel forms its two coefficients. The x coefficient uses sine when
  // x_sin is set and cosine otherwise; the y coefficient uses the other one.
  typedef struct packed {
    logic x_sin;
    logic x_neg;
    logic y_neg;
  } coef_t;

  localparam coef_t WHEEL_ONE_COEF   = '{x_sin: 1'b0, x_neg: 1'b1, y_neg: 1'b1};
  localparam coef_t WHEEL_TWO_COEF   = '{x_sin: 1'b1, x_neg: 1'b0, y_neg: 1'b1};
  localparam coef_t WHEEL_THREE_COEF = '{x_sin: 1'b0, x_neg: 1'b0, y_neg: 1'b0};

endpackage

FILE: sv/towik_wheel.sv
`timescale 1ns / 1ps
// One wheel lane: sine lookup, coefficient products, gain and output scaling.
module towik_wheel
  import towik_pkg::*;
#(
  parameter int SINE_TABLE_ENTRIES = DEFAULT_SINE_TABLE_ENTRIES
) (
  input  logic                  clk,
  input  logic [NUM_STAGES-1:0] en,
  input  logic signed [15:0]    vel_x,
  input  logic signed [15:0]    vel_y,
  input  logic signed [15:0]    turn_rate,
  input  logic [15:0]           heading,
  input  logic [15:0]           lever_arm_gain,
  input  logic [15:0]           output_scale,
  input  logic [15:0]           angle_offset,
  input  coef_t                 coef,
  output logic signed [15:0]    speed
);

  localparam int IdxW  = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int ProdW = 15 + IdxW;
  localparam int SW    = 40;
  localparam int PW    = 58;
  localparam int RW    = PW - 23;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned TaylorDiv [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                                64'd156};

  typedef logic [14:0] sine_rom_t [0:SINE_TABLE_ENTRIES];

  // Quarter-wave table, evaluated at elaboration with a truncated Q30 series.
  function automatic sine_rom_t build_sine();
    sine_rom_t         tab;
    longint unsigned   x;
    longint unsigned   term;
    longint unsigned   sum;
    longint unsigned   v;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      x = (HalfPiQ30 * 64'(k) + 64'(SINE_TABLE_ENTRIES / 2)) / 64'(SINE_TABLE_ENTRIES);
      term = x;
      sum  = x;
      for (int n = 1; n <= 6; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / TaylorDiv[n-1];
        if ((n & 1) != 0) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tab[k] = v[14:0];
    end
    return tab;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  // Folds an angle onto the first quadrant; returns {negate, table index}.
  function automatic logic [IdxW:0] sine_addr(input logic [15:0] ang);
    logic [14:0]      ph;
    logic [ProdW-1:0] prod;
    ph   = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    prod = ProdW'(ph) * ProdW'(SINE_TABLE_ENTRIES);
    return {ang[15], prod[14 +: IdxW]};
  endfunction

  // Stage 1: angle and table addresses.
  logic [15:0]        angle;
  logic [IdxW:0]      sin_addr;
  logic [IdxW:0]      cos_addr;
  logic [IdxW-1:0]    sin_idx;
  logic [IdxW-1:0]    cos_idx;
  logic               sin_neg1;
  logic               cos_neg1;
  logic signed [15:0] vx1;
  logic signed [15:0] vy1;
  logic signed [15:0] w1;

  always_comb begin
    angle    = heading + angle_offset;
    sin_addr = sine_addr(angle);
    cos_addr = sine_addr(angle + QUARTER_TURN);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sin_idx  <= sin_addr[IdxW-1:0];
      cos_idx  <= cos_addr[IdxW-1:0];
      sin_neg1 <= sin_addr[IdxW];
      cos_neg1 <= cos_addr[IdxW];
      vx1      <= vel_x;
      vy1      <= vel_y;
      w1       <= turn_rate;
    end
  end

  // Stage 2: table read and turn term.
  logic [14:0]        sin_mag;
  logic [14:0]        cos_mag;
  logic               sin_neg2;
  logic               cos_neg2;
  logic signed [32:0] gw2;
  logic signed [15:0] vx2;
  logic signed [15:0] vy2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sin_mag  <= SINE_ROM[sin_idx];
      cos_mag  <= SINE_ROM[cos_idx];
      sin_neg2 <= sin_neg1;
      cos_neg2 <= cos_neg1;
      gw2      <= 33'($signed({1'b0, lever_arm_gain})) * 33'(w1);
      vx2      <= vx1;
      vy2      <= vy1;
    end
  end

  // Stage 3: coefficient products on magnitudes, signs carried aside.
  logic [14:0]        x_mag;
  logic [14:0]        y_mag;
  logic               x_neg;
  logic               y_neg;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic               x_neg3;
  logic               y_neg3;
  logic signed [32:0] gw3;

  always_comb begin
    x_mag = coef.x_sin ? sin_mag : cos_mag;
    y_mag = coef.x_sin ? cos_mag : sin_mag;
    x_neg = (coef.x_sin ? sin_neg2 : cos_neg2) ^ coef.x_neg;
    y_neg = (coef.x_sin ? cos_neg2 : sin_neg2) ^ coef.y_neg;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      px     <= 32'($signed({1'b0, x_mag})) * 32'(vx2);
      py     <= 32'($signed({1'b0, y_mag})) * 32'(vy2);
      x_neg3 <= x_neg;
      y_neg3 <= y_neg;
      gw3    <= gw2;
    end
  end

  // Stage 4: exact Q15 sum.
  logic signed [SW-1:0] px_ext;
  logic signed [SW-1:0] py_ext;
  logic signed [SW-1:0] s;

  always_comb begin
    px_ext = SW'(px);
    py_ext = SW'(py);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s <= (x_neg3 ? -px_ext : px_ext) + (y_neg3 ? -py_ext : py_ext)
           + (SW'(gw3) <<< 7);
    end
  end

  // Stage 5: output scale as two partial products.
  logic [35:0]        plo;
  logic signed [36:0] phi;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      plo <= 36'(s[19:0]) * 36'(output_scale);
      phi <= 37'($signed(s[SW-1:20])) * 37'($signed({1'b0, output_scale}));
    end
  end

  // Stage 6: recombine and round to nearest, ties upward.
  logic signed [PW-1:0] p;
  logic signed [PW-1:0] p_rnd;
  logic signed [RW-1:0] rnd;

  always_comb begin
    p     = (PW'(phi) <<< 20) + PW'($signed({1'b0, plo}));
    p_rnd = (p + (PW'(1) <<< 22)) >>> 23;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      rnd <= p_rnd[RW-1:0];
    end
  end

  // Stage 7: saturate into the output register.
  always_ff @(posedge clk) begin
    if (en[6]) begin
      if (rnd > RW'(32767)) begin
        speed <= 16'sh7FFF;
      end else if (rnd < -RW'(32768)) begin
        speed <= 16'sh8000;
      end else begin
        speed <= rnd[15:0];
      end
    end
  end

endmodule

FILE: sv/three_wheel_omni_inverse_kinematics_core.sv
`timescale 1ns / 1ps
// An accepted request passes through the seven lane stages before its wheel speeds reach the result port.
// Throughput: one request per cycle; each wheel lane has its own two-port sine ROM and
// a seven-stage multiply chain, with the 40 x 16 output scaling split over two stages.
// A stall only reaches the request side once every stage holds an item.
// Reset (rst, synchronous) clears all stage valid bits and sets both gains to 1.0 (256).
// The sine table is a constant ROM, so no clearing pass follows reset.
module three_wheel_omni_inverse_kinematics_core
  import towik_pkg::*;
#(
  parameter int SINE_TABLE_ENTRIES = DEFAULT_SINE_TABLE_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  logic signed [15:0]     vel_x,
  input  logic signed [15:0]     vel_y,
  input  logic signed [15:0]     turn_rate,
  input  logic [15:0]            heading,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic signed [15:0]     wheel_one_speed,
  output logic signed [15:0]     wheel_two_speed,
  output logic signed [15:0]     wheel_three_speed,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers. Writes are always taken; unknown indexes are dropped.
  logic [15:0] lever_arm_gain;
  logic [15:0] output_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lever_arm_gain <= GAIN_ONE;
      output_scale   <= GAIN_ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEVER_ARM_GAIN: lever_arm_gain <= cfg_data;
        REG_OUTPUT_SCALE:   output_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the lane data. A stage loads when it is empty or
  // when the stage after it moves, so bubbles are squeezed out under a stall and
  // a request can still be taken while a finished result waits on the output.
  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || !rsp_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !stage_valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (en[0]) begin
        stage_valid[0] <= cmd_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  assign cmd_stall = !en[0];
  assign rsp_valid = stage_valid[NUM_STAGES-1];

  // The three lanes differ only in the heading offset and in how each one
  // picks and signs its sine and cosine coefficients.
  towik_wheel #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_wheel_one (
    .clk           (clk),
    .en            (en),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .turn_rate     (turn_rate),
    .heading       (heading),
    .lever_arm_gain(lever_arm_gain),
    .output_scale  (output_scale),
    .angle_offset  (ANGLE_ZERO),
    .coef          (WHEEL_ONE_COEF),
    .speed         (wheel_one_speed)
  );

  towik_wheel #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_wheel_two (
    .clk           (clk),
    .en            (en),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .turn_rate     (turn_rate),
    .heading       (heading),
    .lever_arm_gain(lever_arm_gain),
    .output_scale  (output_scale),
    .angle_offset  (ANGLE_30),
    .coef          (WHEEL_TWO_COEF),
    .speed         (wheel_two_speed)
  );

  towik_wheel #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_wheel_three (
    .clk           (clk),
    .en            (en),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .turn_rate     (turn_rate),
    .heading       (heading),
    .lever_arm_gain(lever_arm_gain),
    .output_scale  (output_scale),
    .angle_offset  (ANGLE_60),
    .coef          (WHEEL_THREE_COEF),
    .speed         (wheel_three_speed)
  );

  // An accepted request occupies the first stage on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> stage_valid[0])
    else $error("accepted request did not enter the pipeline");

  // The request side only stalls when the result side is holding a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (rsp_valid && rsp_stall))
    else $error("request stalled while the pipeline could advance");

  // A taken result with nothing behind it leaves the output empty.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall && !stage_valid[NUM_STAGES-2] |=> !rsp_valid)
    else $error("result repeated after it was taken");

endmodule
